### hw/rtl/fpr_pkg.sv
package fpr_pkg;

	localparam int FRAMES      = 16;
	localparam int PAGE_BITS   = 16;
	localparam int CFG_W       = 5;
	localparam int COUNT_W     = 16;
	localparam int FRAME_IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(4);
	localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_LOAD,
		ST_FINISH
	} state_t;

endpackage

### hw/rtl/fpr_if.sv
interface fpr_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [fpr_pkg::PAGE_BITS-1:0] page;

	modport source (output valid, output command, output page, input ready);
	modport sink   (input valid, input command, input page, output ready);
endinterface

interface fpr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        fault;
	logic [fpr_pkg::COUNT_W-1:0] fault_count;

	modport source (output valid, output fault, output fault_count, input ready);
	modport sink   (input valid, input fault, input fault_count, output ready);
endinterface

### hw/rtl/fifo_page_replacement.sv
// FIFO page replacement over up to FRAMES resident frames.
//
// req channel carries one word per command: a page request or a clear.
// rsp channel returns one word per command: the fault flag and the
// saturating fault count after that command.
// cfg_we/cfg_wdata set the number of frames in use; write only while idle.
//
// Pages sit in a single-port-read, single-port-write RAM with a registered
// read; the search walks the frames one read at a time and a miss
// moves the frames down by one through the same RAM port.
// A clear goes straight to the response; a page request reads and compares
// the frames in order and, on a miss, shifts them down and loads the page.
// One command is in flight at a time and the next is taken in the cycle after
// the response word is loaded.
//
// Reset empties all frames (valid bits in flip-flops), zeroes the count and
// sets four frames in use. The page RAM itself is not cleared.
// The response sits in an output register; a new command is taken while it
// waits, and a finished command holds until the register is free.
module fifo_page_replacement (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [fpr_pkg::CFG_W-1:0] cfg_wdata,
	fpr_req_if.sink                  req,
	fpr_rsp_if.source                rsp
);

	import fpr_pkg::*;

	state_t state_q, state_d;

	logic [CFG_W-1:0]       frame_count_q;
	logic [FRAME_IDX_W-1:0] last_d;
	logic [FRAME_IDX_W-1:0] last_q;
	logic [FRAME_IDX_W-1:0] idx_q;
	logic [PAGE_BITS-1:0]   page_q;
	logic [FRAMES-1:0]      valid_q;
	logic [FRAMES-1:0]      valid_shift;
	logic [COUNT_W-1:0]     total_q;
	logic                   res_fault_q;

	logic                   out_valid_q;
	logic                   out_fault_q;
	logic [COUNT_W-1:0]     out_count_q;

	logic                   ram_we;
	logic [FRAME_IDX_W-1:0] ram_waddr;
	logic [PAGE_BITS-1:0]   ram_wdata;
	logic                   ram_re;
	logic [FRAME_IDX_W-1:0] ram_raddr;
	logic [PAGE_BITS-1:0]   ram_rdata;

	logic                   accept;
	logic                   hit;
	logic                   out_free;

	fpr_page_ram #(
		.DEPTH (FRAMES),
		.WIDTH (PAGE_BITS),
		.AW    (FRAME_IDX_W)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// clamp frames in use to 1..FRAMES, kept as index of youngest frame
	always_comb begin
		if (frame_count_q == '0) begin
			last_d = '0;
		end else if (32'(frame_count_q) > FRAMES) begin
			last_d = FRAME_IDX_W'(FRAMES - 1);
		end else begin
			last_d = FRAME_IDX_W'(frame_count_q - 1'b1);
		end
	end

	always_comb begin
		for (int i = 0; i < FRAMES - 1; i++) begin
			if (FRAME_IDX_W'(i) < last_q) begin
				valid_shift[i] = valid_q[i+1];
			end else if (FRAME_IDX_W'(i) == last_q) begin
				valid_shift[i] = 1'b1;
			end else begin
				valid_shift[i] = valid_q[i];
			end
		end
		valid_shift[FRAMES-1] = (FRAME_IDX_W'(FRAMES - 1) == last_q) ? 1'b1
			: valid_q[FRAMES-1];
	end

	assign accept   = req.valid && req.ready;
	assign hit      = valid_q[idx_q] && (ram_rdata == page_q);
	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = (req.command == CMD_CLEAR) ? ST_FINISH : ST_RD;
				end
			end
			ST_RD: begin
				ram_re  = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				priority if (hit) begin
					state_d = ST_FINISH;
				end else if (idx_q == last_q) begin
					state_d = (last_q == '0) ? ST_LOAD : ST_SH_RD;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_SH_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q + 1'b1;
				state_d   = ST_SH_WR;
			end
			ST_SH_WR: begin
				ram_we  = 1'b1;
				state_d = (idx_q + 1'b1 == last_q) ? ST_LOAD : ST_SH_RD;
			end
			ST_LOAD: begin
				ram_we    = 1'b1;
				ram_waddr = last_q;
				ram_wdata = page_q;
				state_d   = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_we) begin
			frame_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			total_q     <= '0;
			res_fault_q <= 1'b0;
		end else begin
			if (accept && req.command == CMD_CLEAR) begin
				valid_q     <= '0;
				total_q     <= '0;
				res_fault_q <= 1'b0;
			end else if (state_q == ST_CMP && hit) begin
				res_fault_q <= 1'b0;
			end else if (state_q == ST_LOAD) begin
				valid_q     <= valid_shift;
				res_fault_q <= 1'b1;
				if (total_q != COUNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= req.page;
			last_q <= last_d;
			idx_q  <= '0;
		end else if (state_q == ST_CMP) begin
			idx_q <= (idx_q == last_q) ? '0 : idx_q + 1'b1;
		end else if (state_q == ST_SH_WR) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_fault_q <= res_fault_q;
			out_count_q <= total_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.fault       = out_fault_q;
	assign rsp.fault_count = out_count_q;

	a_load_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD && total_q != COUNT_MAX |=> total_q == $past(total_q) + 1'b1)
		else $error("fault count did not rise on a miss");

	a_search_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_CMP) |-> idx_q <= last_q)
		else $error("search index beyond frames in use");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_RD || state_q == ST_SH_WR) |-> idx_q < last_q)
		else $error("shift index beyond frames in use");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.command == CMD_CLEAR |=> valid_q == '0 && total_q == '0)
		else $error("clear left frames or count");

	a_load_youngest: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD |=> valid_q[$past(last_q)])
		else $error("youngest frame not marked after load");

endmodule

### hw/rtl/fpr_page_ram.sv
module fpr_page_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
